// ===== hw/rtl/par_pkg.sv =====
// ----------------------------------------------------------------------------
// par_pkg
// Shared types, constants and command/status records of the packet address
// reflector.
// ----------------------------------------------------------------------------
`default_nettype none

package par_pkg;

  // header buffer depth default
  localparam int unsigned HEADER_BYTES = 64;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ETHERNET_MODE   = 2'd0,
    CFG_MULTICAST_FLOOR = 2'd1,
    CFG_MAC_PREFIX      = 2'd2
  } cfg_idx_e;

  localparam logic [7:0]  MULTICAST_FLOOR_RST = 8'd224;
  localparam logic [15:0] MAC_PREFIX_RST      = 16'h0200;

  // ethertypes and ip versions
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [3:0]  IP_VER_4   = 4'd4;
  localparam logic [3:0]  IP_VER_6   = 4'd6;

  // header layout, byte offsets
  localparam int unsigned ETH_HDR      = 14;
  localparam int unsigned MAC_LEN      = 6;
  localparam int unsigned ETH_TYPE     = 12;
  localparam int unsigned IP4_SRC      = 12;
  localparam int unsigned IP4_DST      = 16;
  localparam int unsigned IP4_ADDR_LEN = 4;
  localparam int unsigned IP4_MIN      = 20;
  localparam int unsigned IP6_SRC      = 8;
  localparam int unsigned IP6_DST      = 24;
  localparam int unsigned IP6_ADDR_LEN = 16;
  localparam int unsigned IP6_MIN      = 40;
  localparam int unsigned ARP_MIN      = 28;
  localparam int unsigned ARP_OPER     = 20;
  localparam int unsigned ARP_SHA      = 22;
  localparam int unsigned ARP_THA      = 32;
  localparam int unsigned ARP_TPA      = 38;
  localparam int unsigned ARP_SWAP_LEN = 10;

  localparam logic [7:0] ARP_OPER_REPLY_HI = 8'h00;
  localparam logic [7:0] ARP_OPER_REPLY_LO = 8'h02;

  // channel payloads
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       dropped;
  } out_t;

  typedef struct packed {
    logic        ethernet_mode;
    logic [7:0]  multicast_floor;
    logic [15:0] mac_prefix;
  } cfg_t;

  // rewrite selected for the current header
  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_IP4,
    KIND_IP6,
    KIND_ARP
  } kind_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DECIDE,
    ST_READ,
    ST_EMIT,
    ST_PASS,
    ST_DISCARD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic hdr_clr;
    logic idx_clr;
    logic rd;
    logic emit;
    logic pass;
    logic drop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_full;
    logic in_last;
    logic keep;
    logic idx_end;
    logic out_free;
    logic frame_last;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/par_ctrl.sv =====
// ----------------------------------------------------------------------------
// par_ctrl
// Frame sequencer: collect header, decide, emit header bytes, then pass
// through or swallow the rest of the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module par_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire par_pkg::status_t status_i,
  output par_pkg::cmd_t        cmd_o
);

  par_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= par_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      par_pkg::ST_COLLECT: begin
        if (accept && (status_i.in_last || status_i.pos_full)) begin
          state_d = par_pkg::ST_DECIDE;
        end
      end
      par_pkg::ST_DECIDE: begin
        if (status_i.keep) begin
          state_d = par_pkg::ST_READ;
        end else if (status_i.out_free) begin
          state_d = status_i.frame_last ? par_pkg::ST_COLLECT : par_pkg::ST_DISCARD;
        end
      end
      par_pkg::ST_READ: begin
        state_d = par_pkg::ST_EMIT;
      end
      par_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          if (!status_i.idx_end) begin
            state_d = par_pkg::ST_READ;
          end else begin
            state_d = status_i.frame_last ? par_pkg::ST_COLLECT : par_pkg::ST_PASS;
          end
        end
      end
      par_pkg::ST_PASS: begin
        if (accept && status_i.in_last) begin
          state_d = par_pkg::ST_COLLECT;
        end
      end
      par_pkg::ST_DISCARD: begin
        if (accept && status_i.in_last) begin
          state_d = par_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_d = par_pkg::ST_COLLECT;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      par_pkg::ST_COLLECT: begin
        in_ready_o  = 1'b1;
        cmd_o.store = accept;
      end
      par_pkg::ST_DECIDE: begin
        if (status_i.keep) begin
          cmd_o.idx_clr = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.drop    = 1'b1;
          cmd_o.hdr_clr = status_i.frame_last;
        end
      end
      par_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      par_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.hdr_clr = status_i.idx_end && status_i.frame_last;
        end
      end
      par_pkg::ST_PASS: begin
        in_ready_o    = status_i.out_free;
        cmd_o.pass    = accept;
        cmd_o.hdr_clr = accept && status_i.in_last;
      end
      par_pkg::ST_DISCARD: begin
        in_ready_o    = 1'b1;
        cmd_o.hdr_clr = accept && status_i.in_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/par_datapath.sv =====
// ----------------------------------------------------------------------------
// par_datapath
// Header buffer, field capture, rewrite decision, address remap and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module par_datapath #(
  parameter int unsigned HEADER_BYTES = par_pkg::HEADER_BYTES
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire par_pkg::cfg_t   cfg_i,
  input  wire par_pkg::in_t    in_data_i,
  input  wire par_pkg::cmd_t   cmd_i,
  output par_pkg::status_t     status_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output par_pkg::out_t        out_data_o
);

  localparam int unsigned AW = $clog2(HEADER_BYTES);
  localparam int unsigned CW = AW + 1;

  logic [7:0]    hdr_mem_q [HEADER_BYTES];
  logic [CW-1:0] pos_q, pos_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          frame_last_q;

  // captured header fields
  logic [7:0] b0_q, b12_q, b13_q, b14_q, b16_q, b30_q;

  par_pkg::kind_e kind;
  logic [15:0]    etype;
  logic [AW-1:0]  off;
  logic [AW-1:0]  src;
  logic           ovr;
  logic [7:0]     ovr_val;
  logic [7:0]     rd_q, ovr_val_q;
  logic           ovr_q;
  logic           idx_end;

  logic          out_valid_q, out_valid_d;
  par_pkg::out_t out_q, out_d;
  logic          out_free;

  // byte position and emit index
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.hdr_clr) begin
      pos_d = '0;
    end else if (cmd_i.store) begin
      pos_d = pos_q + CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.emit) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      idx_q <= '0;
    end else begin
      pos_q <= pos_d;
      idx_q <= idx_d;
    end
  end

  // field capture while collecting
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      frame_last_q <= in_data_i.in_last;
      if (pos_q == CW'(0)) begin
        b0_q <= in_data_i.in_byte;
      end
      if (pos_q == CW'(par_pkg::ETH_TYPE)) begin
        b12_q <= in_data_i.in_byte;
      end
      if (pos_q == CW'(par_pkg::ETH_TYPE + 1)) begin
        b13_q <= in_data_i.in_byte;
      end
      if (pos_q == CW'(par_pkg::ETH_HDR)) begin
        b14_q <= in_data_i.in_byte;
      end
      if (pos_q == CW'(par_pkg::IP4_DST)) begin
        b16_q <= in_data_i.in_byte;
      end
      if (pos_q == CW'(par_pkg::ETH_HDR + par_pkg::IP4_DST)) begin
        b30_q <= in_data_i.in_byte;
      end
    end
  end

  // rewrite decision from captured fields and length
  assign etype = {b12_q, b13_q};

  always_comb begin
    kind = par_pkg::KIND_DROP;
    if (!cfg_i.ethernet_mode) begin
      if (b0_q[7:4] == par_pkg::IP_VER_4) begin
        if (pos_q >= CW'(par_pkg::IP4_MIN) && b16_q < cfg_i.multicast_floor) begin
          kind = par_pkg::KIND_IP4;
        end
      end else if (b0_q[7:4] == par_pkg::IP_VER_6) begin
        if (pos_q >= CW'(par_pkg::IP6_MIN)) begin
          kind = par_pkg::KIND_IP6;
        end
      end
    end else if (pos_q >= CW'(par_pkg::ETH_HDR)) begin
      if (etype == par_pkg::ETYPE_IPV4 || etype == par_pkg::ETYPE_IPV6) begin
        if (pos_q >= CW'(par_pkg::ETH_HDR + 1)) begin
          if (b14_q[7:4] == par_pkg::IP_VER_4) begin
            if (pos_q >= CW'(par_pkg::ETH_HDR + par_pkg::IP4_MIN) &&
                b30_q < cfg_i.multicast_floor) begin
              kind = par_pkg::KIND_IP4;
            end
          end else if (b14_q[7:4] == par_pkg::IP_VER_6) begin
            if (pos_q >= CW'(par_pkg::ETH_HDR + par_pkg::IP6_MIN)) begin
              kind = par_pkg::KIND_IP6;
            end
          end
        end
      end else if (etype == par_pkg::ETYPE_ARP) begin
        if (pos_q >= CW'(par_pkg::ETH_HDR + par_pkg::ARP_MIN)) begin
          kind = par_pkg::KIND_ARP;
        end
      end
    end
  end

  // map output index to source entry or constant
  assign off = cfg_i.ethernet_mode ? AW'(par_pkg::ETH_HDR) : '0;

  always_comb begin
    src     = idx_q;
    ovr     = 1'b0;
    ovr_val = '0;
    unique case (kind)
      par_pkg::KIND_IP4: begin
        if (idx_q >= off + AW'(par_pkg::IP4_SRC) && idx_q < off + AW'(par_pkg::IP4_DST)) begin
          src = idx_q + AW'(par_pkg::IP4_ADDR_LEN);
        end else if (idx_q >= off + AW'(par_pkg::IP4_DST) &&
                     idx_q < off + AW'(par_pkg::IP4_DST + par_pkg::IP4_ADDR_LEN)) begin
          src = idx_q - AW'(par_pkg::IP4_ADDR_LEN);
        end
      end
      par_pkg::KIND_IP6: begin
        if (idx_q >= off + AW'(par_pkg::IP6_SRC) && idx_q < off + AW'(par_pkg::IP6_DST)) begin
          src = idx_q + AW'(par_pkg::IP6_ADDR_LEN);
        end else if (idx_q >= off + AW'(par_pkg::IP6_DST) &&
                     idx_q < off + AW'(par_pkg::IP6_DST + par_pkg::IP6_ADDR_LEN)) begin
          src = idx_q - AW'(par_pkg::IP6_ADDR_LEN);
        end
      end
      par_pkg::KIND_ARP: begin
        // reply: new sender mac, operation, sender and target exchanged
        priority if (idx_q < AW'(par_pkg::MAC_LEN)) begin
          src = idx_q + AW'(par_pkg::MAC_LEN);
        end else if (idx_q == AW'(par_pkg::MAC_LEN) || idx_q == AW'(par_pkg::ARP_SHA)) begin
          ovr     = 1'b1;
          ovr_val = cfg_i.mac_prefix[15:8];
        end else if (idx_q == AW'(par_pkg::MAC_LEN + 1) ||
                     idx_q == AW'(par_pkg::ARP_SHA + 1)) begin
          ovr     = 1'b1;
          ovr_val = cfg_i.mac_prefix[7:0];
        end else if (idx_q < AW'(2 * par_pkg::MAC_LEN)) begin
          src = idx_q + AW'(par_pkg::ARP_TPA - par_pkg::MAC_LEN - 2);
        end else if (idx_q == AW'(par_pkg::ARP_OPER)) begin
          ovr     = 1'b1;
          ovr_val = par_pkg::ARP_OPER_REPLY_HI;
        end else if (idx_q == AW'(par_pkg::ARP_OPER + 1)) begin
          ovr     = 1'b1;
          ovr_val = par_pkg::ARP_OPER_REPLY_LO;
        end else if (idx_q >= AW'(par_pkg::ARP_SHA + 2) &&
                     idx_q < AW'(par_pkg::ARP_SHA + par_pkg::MAC_LEN)) begin
          src = idx_q + AW'(par_pkg::ARP_TPA - par_pkg::ARP_SHA - 2);
        end else if (idx_q >= AW'(par_pkg::ARP_SHA + par_pkg::MAC_LEN) &&
                     idx_q < AW'(par_pkg::ARP_THA)) begin
          src = idx_q + AW'(par_pkg::ARP_TPA - par_pkg::ARP_SHA - par_pkg::MAC_LEN);
        end else if (idx_q >= AW'(par_pkg::ARP_THA) &&
                     idx_q < AW'(par_pkg::ARP_THA + par_pkg::ARP_SWAP_LEN)) begin
          src = idx_q - AW'(par_pkg::ARP_THA - par_pkg::ARP_SHA);
        end
      end
      default: begin
        src = idx_q;
      end
    endcase
    // ethernet mac swap on kept ip frames
    if (cfg_i.ethernet_mode &&
        (kind == par_pkg::KIND_IP4 || kind == par_pkg::KIND_IP6)) begin
      if (idx_q < AW'(par_pkg::MAC_LEN)) begin
        src = idx_q + AW'(par_pkg::MAC_LEN);
      end else if (idx_q < AW'(2 * par_pkg::MAC_LEN)) begin
        src = idx_q - AW'(par_pkg::MAC_LEN);
      end
    end
  end

  // header buffer, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      hdr_mem_q[pos_q[AW-1:0]] <= in_data_i.in_byte;
    end
    if (cmd_i.rd) begin
      rd_q      <= hdr_mem_q[src];
      ovr_q     <= ovr;
      ovr_val_q <= ovr_val;
    end
  end

  assign idx_end  = ({1'b0, idx_q} + CW'(1)) == pos_q;
  assign out_free = !out_valid_q || out_ready_i;

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (cmd_i.emit) begin
      out_valid_d    = 1'b1;
      out_d.out_byte = ovr_q ? ovr_val_q : rd_q;
      out_d.out_last = frame_last_q && idx_end;
      out_d.dropped  = 1'b0;
    end else if (cmd_i.pass) begin
      out_valid_d    = 1'b1;
      out_d.out_byte = in_data_i.in_byte;
      out_d.out_last = in_data_i.in_last;
      out_d.dropped  = 1'b0;
    end else if (cmd_i.drop) begin
      out_valid_d    = 1'b1;
      out_d.out_byte = '0;
      out_d.out_last = 1'b1;
      out_d.dropped  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to controller
  assign status_o.pos_full   = pos_q == CW'(HEADER_BYTES - 1);
  assign status_o.in_last    = in_data_i.in_last;
  assign status_o.keep       = kind != par_pkg::KIND_DROP;
  assign status_o.idx_end    = idx_end;
  assign status_o.out_free   = out_free;
  assign status_o.frame_last = frame_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/packet_address_reflector.sv =====
// ----------------------------------------------------------------------------
// packet_address_reflector
// Turns a received frame into its reply: swaps IP and MAC addresses, builds
// ARP replies and drops frames that cannot be answered.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_ready_o   par_pkg::in_t  (byte, last)
//  out      output     out_valid_o / out_ready_i par_pkg::out_t (byte, last, dropped)
//  cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Header bytes are taken one per cycle up to HEADER_BYTES or the frame end.
// A decision state follows; each header byte then passes through the
// buffer's registered read and the output register. Bytes past the header
// pass one per cycle while the output is free, dropped-frame bytes one per
// cycle. Reset clears the controller, counters, output valid flag and
// configuration registers; the header buffer is not cleared and needs no
// clearing pass. A stalled output holds the output register; input is taken
// while a result waits only where the controller is collecting or swallowing.
`default_nettype none

module packet_address_reflector #(
  parameter int unsigned HEADER_BYTES = par_pkg::HEADER_BYTES
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [par_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [par_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire par_pkg::in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output par_pkg::out_t                         out_data_o
);

  par_pkg::cfg_t    cfg_q;
  par_pkg::cmd_t    cmd;
  par_pkg::status_t status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ethernet_mode   <= 1'b0;
      cfg_q.multicast_floor <= par_pkg::MULTICAST_FLOOR_RST;
      cfg_q.mac_prefix      <= par_pkg::MAC_PREFIX_RST;
    end else if (cfg_we_i) begin
      unique case (par_pkg::cfg_idx_e'(cfg_index_i))
        par_pkg::CFG_ETHERNET_MODE:   cfg_q.ethernet_mode   <= cfg_wdata_i[0];
        par_pkg::CFG_MULTICAST_FLOOR: cfg_q.multicast_floor <= cfg_wdata_i[7:0];
        par_pkg::CFG_MAC_PREFIX:      cfg_q.mac_prefix      <= cfg_wdata_i[15:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // frame sequencer
  par_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // buffer and rewrite datapath
  par_datapath #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/par_checker.sv =====
// ----------------------------------------------------------------------------
// par_checker
// Port-level checks of the packet address reflector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module par_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire par_pkg::in_t                   in_data_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire par_pkg::out_t                  out_data_o
);

  // waiting input request holds with its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && in_data_i == $past(in_data_i))
    else $error("input request changed while waiting");

  // stalled request holds with its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && out_data_o == $past(out_data_o))
    else $error("output request changed while stalled");

  // drop result carries a zero byte
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dropped |-> out_data_o.out_byte == 8'h00)
    else $error("drop result with nonzero byte");

  // drop result closes the frame
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dropped |-> out_data_o.out_last)
    else $error("drop result without last flag");

endmodule

bind packet_address_reflector par_checker u_par_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet address reflector. Frames are sent one
// byte per request, first from a table of hand-picked cases, then as random
// frames under three idle patterns. A behavioral copy of the header rewrite
// predicts all replies but typed-in drops, compared field by field on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int HDR_N          = par_pkg::HEADER_BYTES;
  localparam int SETTLE_CYCLES  = 2 * HDR_N + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BUDGET  = 35;
  localparam int N_DIRECTED     = 12;

  // index past the register list, the block must ignore it
  localparam logic [par_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  localparam par_pkg::out_t DROP_REPLY = '{out_byte: 8'h00, out_last: 1'b1, dropped: 1'b1};

  typedef enum int {
    FK_IP4,
    FK_IP6,
    FK_ARP,
    FK_BAD_ETYPE,
    FK_BAD_VER,
    FK_NOISE
  } frame_kind_e;

  // one directed frame: mode, kind, length, ipv4 destination octet,
  // fill byte (-1 for random) and whether a plain drop is expected
  typedef struct packed {
    logic        eth;
    frame_kind_e kind;
    int          len;
    int          dst;
    int          fill;
    logic        typed_drop;
  } frame_row_t;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         cfg_we_i    = 1'b0;
  logic [par_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [par_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic         in_valid_i  = 1'b0;
  logic         in_ready_o;
  par_pkg::in_t in_data_i   = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  par_pkg::out_t out_data_o;

  // predictor state and shadow registers
  logic [7:0]   hdr_buf [HDR_N];
  int           hdr_fill;
  logic         swallowing;
  logic         eth_mode_m;
  logic [7:0]   floor_m;
  logic [15:0]  prefix_m;

  par_pkg::out_t reply_q [$];
  par_pkg::out_t fresh_q [$];
  logic [7:0]   frame_bytes [$];
  frame_row_t   dir_rows [N_DIRECTED];

  int           tx_idle_pct = 14;
  int           rx_idle_pct = 70;
  int           mismatches  = 0;
  int           quiet_cycles = 0;

  packet_address_reflector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // header rewrite prediction
  function automatic void swap_hdr(int a, int b, int n);
    logic [7:0] t;
    for (int i = 0; i < n; i++) begin
      t              = hdr_buf[a + i];
      hdr_buf[a + i] = hdr_buf[b + i];
      hdr_buf[b + i] = t;
    end
  endfunction

  function automatic logic rewrite_ip(int off, int len);
    logic [3:0] ver;
    if (len < off + 1) return 1'b0;
    ver = hdr_buf[off][7:4];
    if (ver == par_pkg::IP_VER_4) begin
      if (len < off + par_pkg::IP4_MIN) return 1'b0;
      if (hdr_buf[off + par_pkg::IP4_DST] >= floor_m) return 1'b0;
      swap_hdr(off + par_pkg::IP4_SRC, off + par_pkg::IP4_DST, par_pkg::IP4_ADDR_LEN);
      return 1'b1;
    end
    if (ver == par_pkg::IP_VER_6) begin
      if (len < off + par_pkg::IP6_MIN) return 1'b0;
      swap_hdr(off + par_pkg::IP6_SRC, off + par_pkg::IP6_DST, par_pkg::IP6_ADDR_LEN);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic rewrite_arp(int len);
    if (len < par_pkg::ETH_HDR + par_pkg::ARP_MIN) return 1'b0;
    hdr_buf[par_pkg::ARP_OPER]     = par_pkg::ARP_OPER_REPLY_HI;
    hdr_buf[par_pkg::ARP_OPER + 1] = par_pkg::ARP_OPER_REPLY_LO;
    // reply mac is the prefix followed by the target ip
    hdr_buf[par_pkg::ARP_THA]      = prefix_m[15:8];
    hdr_buf[par_pkg::ARP_THA + 1]  = prefix_m[7:0];
    for (int i = 0; i < par_pkg::IP4_ADDR_LEN; i++) begin
      hdr_buf[par_pkg::ARP_THA + 2 + i] = hdr_buf[par_pkg::ARP_TPA + i];
    end
    for (int i = 0; i < par_pkg::MAC_LEN; i++) hdr_buf[i] = hdr_buf[par_pkg::ARP_THA + i];
    swap_hdr(par_pkg::ARP_SHA, par_pkg::ARP_THA, par_pkg::ARP_SWAP_LEN);
    return 1'b1;
  endfunction

  function automatic logic rewrite_hdr(int len);
    logic [15:0] etype;
    logic        keep;
    if (!eth_mode_m) return rewrite_ip(0, len);
    if (len < par_pkg::ETH_HDR) return 1'b0;
    etype = {hdr_buf[par_pkg::ETH_TYPE], hdr_buf[par_pkg::ETH_TYPE + 1]};
    if (etype == par_pkg::ETYPE_IPV4 || etype == par_pkg::ETYPE_IPV6) begin
      keep = rewrite_ip(par_pkg::ETH_HDR, len);
    end else if (etype == par_pkg::ETYPE_ARP) begin
      keep = rewrite_arp(len);
    end else begin
      keep = 1'b0;
    end
    if (keep) swap_hdr(0, par_pkg::MAC_LEN, par_pkg::MAC_LEN);
    return keep;
  endfunction

  // replies caused by one accepted byte, left in fresh_q
  function automatic void reflect_byte(par_pkg::in_t item);
    int n;
    fresh_q.delete();
    if (swallowing) begin
      if (item.in_last) begin
        swallowing = 1'b0;
        hdr_fill   = 0;
      end
      return;
    end
    // tail of a kept frame passes straight through
    if (hdr_fill >= HDR_N) begin
      fresh_q.push_back('{out_byte: item.in_byte, out_last: item.in_last, dropped: 1'b0});
      if (item.in_last) hdr_fill = 0;
      return;
    end
    hdr_buf[hdr_fill] = item.in_byte;
    hdr_fill++;
    if (hdr_fill < HDR_N && !item.in_last) return;
    n = hdr_fill;
    if (!rewrite_hdr(n)) begin
      fresh_q.push_back(DROP_REPLY);
      hdr_fill   = 0;
      swallowing = !item.in_last;
      return;
    end
    for (int i = 0; i < n; i++) begin
      fresh_q.push_back('{out_byte: hdr_buf[i], out_last: item.in_last && (i + 1 == n),
                          dropped: 1'b0});
    end
    if (item.in_last) hdr_fill = 0;
  endfunction

  // frame builder, result left in frame_bytes
  function automatic void build_frame(frame_kind_e kind, logic eth, int len, int dst,
                                      int fill);
    int          off;
    logic [15:0] etype;
    logic [3:0]  ver;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    off = eth ? par_pkg::ETH_HDR : 0;
    case (kind)
      FK_ARP: etype = par_pkg::ETYPE_ARP;
      FK_BAD_ETYPE: begin
        do etype = 16'($urandom);
        while (etype == par_pkg::ETYPE_IPV4 || etype == par_pkg::ETYPE_IPV6 ||
               etype == par_pkg::ETYPE_ARP);
      end
      // the version nibble, not the ethertype, picks v4 or v6
      default: etype = $urandom_range(0, 1) ? par_pkg::ETYPE_IPV4 : par_pkg::ETYPE_IPV6;
    endcase
    if (eth && kind != FK_NOISE && len > par_pkg::ETH_TYPE + 1) begin
      frame_bytes[par_pkg::ETH_TYPE]     = etype[15:8];
      frame_bytes[par_pkg::ETH_TYPE + 1] = etype[7:0];
    end
    case (kind)
      FK_IP4:     ver = par_pkg::IP_VER_4;
      FK_IP6:     ver = par_pkg::IP_VER_6;
      FK_BAD_VER: begin
        do ver = 4'($urandom);
        while (ver == par_pkg::IP_VER_4 || ver == par_pkg::IP_VER_6);
      end
      default:    ver = '0;
    endcase
    if (len > off && (kind == FK_IP4 || kind == FK_IP6 || kind == FK_BAD_VER)) begin
      frame_bytes[off] = (frame_bytes[off] & 8'h0f) | {ver, 4'h0};
    end
    if (kind == FK_IP4 && len > off + par_pkg::IP4_DST) begin
      frame_bytes[off + par_pkg::IP4_DST] = 8'(dst);
    end
  endfunction

  // send frame_bytes, one request per byte
  task automatic send_frame(logic typed_drop);
    par_pkg::in_t item;
    foreach (frame_bytes[i]) begin
      item.in_byte = frame_bytes[i];
      item.in_last = (i == frame_bytes.size() - 1);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= item;
      do @(posedge clk_i);
      while (!in_ready_o);
      reflect_byte(item);
      // obvious drops are typed in, everything else comes from the predictor
      if (typed_drop) begin
        if (fresh_q.size() != 0) reply_q.push_back(DROP_REPLY);
      end else begin
        foreach (fresh_q[k]) reply_q.push_back(fresh_q[k]);
      end
    end
  endtask

  // hold off the sender until every reply is back
  task automatic pause_for_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (reply_q.size() != 0);
  endtask

  task automatic wait_idle();
    pause_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [par_pkg::CFG_IDX_W-1:0] idx,
                           logic [par_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      par_pkg::CFG_ETHERNET_MODE:   eth_mode_m = val[0];
      par_pkg::CFG_MULTICAST_FLOOR: floor_m    = val[7:0];
      par_pkg::CFG_MAC_PREFIX:      prefix_m   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // idle the block, then write every register plus the unused index
  task automatic apply_settings(logic [15:0] eth_w, logic [15:0] floor_w,
                                logic [15:0] prefix_w);
    wait_idle();
    cfg_write(CFG_IDX_UNUSED, 16'($urandom));
    cfg_write(par_pkg::CFG_ETHERNET_MODE, eth_w);
    cfg_write(par_pkg::CFG_MULTICAST_FLOOR, floor_w);
    cfg_write(par_pkg::CFG_MAC_PREFIX, prefix_w);
    cfg_we_i <= 1'b0;
  endtask

  // random frames, mostly well-formed and near minimum length
  task automatic random_frames(int budget);
    int          sent;
    int          r;
    int          minl;
    int          len;
    int          dst;
    frame_kind_e kind;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        case ($urandom_range(0, eth_mode_m ? 2 : 1))
          0:       kind = FK_IP4;
          1:       kind = FK_IP6;
          default: kind = FK_ARP;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       kind = eth_mode_m ? FK_BAD_ETYPE : FK_BAD_VER;
          1:       kind = FK_BAD_VER;
          default: kind = FK_NOISE;
        endcase
      end
      case (kind)
        FK_IP6:  minl = par_pkg::IP6_MIN;
        FK_ARP:  minl = par_pkg::ARP_MIN;
        default: minl = par_pkg::IP4_MIN;
      endcase
      if (eth_mode_m) minl += par_pkg::ETH_HDR;
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(1, minl - 1);
      else if (r < 88) len = minl + $urandom_range(0, 6);
      else len = $urandom_range(HDR_N - 2, HDR_N + 20);
      // destination octet either random or at or just below the floor
      if ($urandom_range(0, 1)) dst = $urandom_range(0, 255);
      else if (floor_m == 0) dst = 0;
      else dst = int'(floor_m) - $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) pause_for_replies();
      build_frame(kind, eth_mode_m, len, dst, -1);
      send_frame(1'b0);
      sent += len;
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // reply checker
  always @(posedge clk_i) begin : check_replies
    par_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected reply: out_byte %0h out_last %0b dropped %0b",
               out_data_o.out_byte, out_data_o.out_last, out_data_o.dropped);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data_o.out_byte);
          mismatches++;
        end
        if (out_data_o.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_data_o.out_last);
          mismatches++;
        end
        if (out_data_o.dropped !== want.dropped) begin
          $error("dropped: expected %0b, got %0b", want.dropped, out_data_o.dropped);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any request or reply moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    hdr_fill   = 0;
    swallowing = 1'b0;
    eth_mode_m = 1'b0;
    floor_m    = par_pkg::MULTICAST_FLOOR_RST;
    prefix_m   = par_pkg::MAC_PREFIX_RST;

    dir_rows = '{
      // bare ip, registers at reset values
      '{1'b0, FK_IP4,       20,  10,  -1, 1'b0},
      '{1'b0, FK_IP4,       20, 224,  -1, 1'b1},
      '{1'b0, FK_IP4,       20, 223, 255, 1'b0},
      '{1'b0, FK_NOISE,      2,   0,   0, 1'b1},
      '{1'b0, FK_IP6,       40,   0,  -1, 1'b0},
      '{1'b0, FK_BAD_VER,    2,   0,  -1, 1'b1},
      '{1'b0, FK_IP4,       19,   0,  -1, 1'b1},
      '{1'b0, FK_IP4,        1,   0,  -1, 1'b1},
      '{1'b0, FK_IP4,       66,   1,  -1, 1'b0},
      // ethernet framing
      '{1'b1, FK_ARP,       42,   0,  -1, 1'b0},
      '{1'b1, FK_BAD_ETYPE, 14,   0,  -1, 1'b1},
      '{1'b1, FK_NOISE,     13,   0,  -1, 1'b1}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].eth != eth_mode_m) begin
        apply_settings(16'(dir_rows[r].eth), 16'(floor_m), prefix_m);
      end
      build_frame(dir_rows[r].kind, dir_rows[r].eth, dir_rows[r].len, dir_rows[r].dst,
                  dir_rows[r].fill);
      send_frame(dir_rows[r].typed_drop);
    end

    // sender mostly busy, receiver mostly stalled; every ipv4 frame dropped
    apply_settings(16'd1, 16'd0, 16'hffff);
    tx_idle_pct = 14;
    rx_idle_pct = 70;
    random_frames(RANDOM_BUDGET);

    // roles swapped; upper bits of the written values must be ignored
    apply_settings(16'hfffe, 16'h12ff, 16'h0000);
    tx_idle_pct = 70;
    rx_idle_pct = 14;
    random_frames(RANDOM_BUDGET);

    // no idling at all
    apply_settings(16'd1, 16'($urandom_range(1, 254)), 16'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_frames(RANDOM_BUDGET);

    wait_idle();
    if (reply_q.size() != 0) $error("%0d expected replies never arrived", reply_q.size());
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
